>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hmlf_pkg.sv
package hmlf_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int TOTAL_W         = 32;
    localparam int KEY_LEN         = 15;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Progress through the CR LF CR LF that closes the header.
    typedef enum logic [1:0] {
        EOL_NONE,
        EOL_CR,
        EOL_CRLF,
        EOL_CRLFCR
    } eol_state_t;

    typedef enum logic [1:0] {
        KP_LINE_START,
        KP_SKIP_LINE,
        KP_FOUND
    } key_phase_t;

    typedef enum logic [1:0] {
        NP_IDLE,
        NP_SPACE,
        NP_DIGITS,
        NP_DONE
    } num_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } in_beat_t;

    typedef struct packed {
        logic               header_found;
        logic               complete;
        logic               length_error;
        logic [TOTAL_W-1:0] total_length;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Lower-case text of the key "content-length:".
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd0:    r = 8'h63; // c
            4'd1:    r = 8'h6F; // o
            4'd2:    r = 8'h6E; // n
            4'd3:    r = 8'h74; // t
            4'd4:    r = 8'h65; // e
            4'd5:    r = 8'h6E; // n
            4'd6:    r = 8'h74; // t
            4'd7:    r = 8'h2D; // -
            4'd8:    r = 8'h6C; // l
            4'd9:    r = 8'h65; // e
            4'd10:   r = 8'h6E; // n
            4'd11:   r = 8'h67; // g
            4'd12:   r = 8'h74; // t
            4'd13:   r = 8'h68; // h
            4'd14:   r = 8'h3A; // :
            default: r = 8'hFF;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/hmlf_in_stage.sv
module hmlf_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hmlf_pkg::in_beat_t s_beat,
    output logic               beat_valid,
    output hmlf_pkg::in_beat_t beat,
    input  logic               beat_take
);
    import hmlf_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // The register refills in the same cycle that the scan stage drains it.
    assign s_ready    = !valid_reg || beat_take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (beat_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

>>> hw/rtl/hmlf_scan.sv
module hmlf_scan #(
    parameter int LENGTH_BITS = hmlf_pkg::LENGTH_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_valid,
    input  hmlf_pkg::in_beat_t beat,
    output logic               beat_take,
    output logic               m_valid,
    input  logic               m_ready,
    output hmlf_pkg::result_t  result
);
    import hmlf_pkg::*;

    localparam int LW = LENGTH_BITS;
    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    eol_state_t    eol_reg,   eol_next,   eol_cur;
    logic          hdr_reg,   hdr_next,   hdr_cur;
    key_phase_t    kp_reg,    kp_next,    kp_cur;
    logic [3:0]    kmp_reg,   kmp_next,   kmp_cur;
    num_phase_t    np_reg,    np_next,    np_cur;
    logic          err_reg,   err_next,   err_cur;
    logic [LW-1:0] bytes_reg, bytes_next, bytes_cur;
    logic [LW-1:0] cv_reg,    cv_next,    cv_cur;
    logic [LW-1:0] total_reg, total_next, total_cur;
    logic          out_valid_reg;
    result_t       result_reg, result_next;

    logic          advance;
    logic [7:0]    c;
    logic          prev_cr;
    logic [3:0]    pos;
    logic [LW+3:0] cv_wide;
    logic [LW+3:0] mac;
    logic [LW:0]   hdr_sum;
    logic          found_now;
    logic          done;
    logic [63:0]   total_ext;

    assign advance   = beat_valid && (!out_valid_reg || m_ready);
    assign beat_take = advance;
    assign m_valid   = out_valid_reg;
    assign result    = result_reg;
    assign c         = beat.data_byte;

    // A beat flagged as first sees the reset state.
    always_comb begin
        eol_cur   = beat.first ? EOL_NONE      : eol_reg;
        hdr_cur   = beat.first ? 1'b0          : hdr_reg;
        kp_cur    = beat.first ? KP_LINE_START : kp_reg;
        kmp_cur   = beat.first ? 4'd0          : kmp_reg;
        np_cur    = beat.first ? NP_IDLE       : np_reg;
        err_cur   = beat.first ? 1'b0          : err_reg;
        bytes_cur = beat.first ? '0            : bytes_reg;
        cv_cur    = beat.first ? '0            : cv_reg;
        total_cur = beat.first ? '0            : total_reg;
    end

    // Times ten plus digit; any bit above LW flags overflow.
    assign cv_wide = {4'b0000, cv_cur};
    assign mac     = (cv_wide << 3) + (cv_wide << 1) + {{LW{1'b0}}, c[3:0]};
    assign prev_cr = (eol_cur == EOL_CR) || (eol_cur == EOL_CRLFCR);
    assign pos     = (kmp_cur < 4'(KEY_LEN)) ? kmp_cur : 4'd0;
    // The content value never changes on a line feed, so the current one is used.
    assign hdr_sum = {1'b0, bytes_next} + {1'b0, cv_cur};

    always_comb begin
        eol_next   = eol_cur;
        hdr_next   = hdr_cur;
        kp_next    = kp_cur;
        kmp_next   = kmp_cur;
        np_next    = np_cur;
        err_next   = err_cur;
        cv_next    = cv_cur;
        total_next = total_cur;
        found_now  = 1'b0;
        bytes_next = (bytes_cur != LEN_MAX) ? bytes_cur + 1'b1 : bytes_cur;

        if (!hdr_cur) begin
            if (c == CH_NUL) begin
                err_next = 1'b1;
            end

            unique case (np_cur)
                NP_SPACE: begin
                    if (!is_space(c)) begin
                        if (c == CH_PLUS) begin
                            np_next = NP_DIGITS;
                        end else if (c == CH_MINUS) begin
                            err_next = 1'b1;
                            np_next  = NP_DONE;
                        end else if (is_digit(c)) begin
                            cv_next = {{(LW-4){1'b0}}, c[3:0]};
                            np_next = NP_DIGITS;
                        end else begin
                            np_next = NP_DONE;
                        end
                    end
                end
                NP_DIGITS: begin
                    if (is_digit(c)) begin
                        if (mac[LW+3:LW] != 4'd0) begin
                            err_next = 1'b1;
                            np_next  = NP_DONE;
                        end else begin
                            cv_next = mac[LW-1:0];
                        end
                    end else begin
                        np_next = NP_DONE;
                    end
                end
                default: begin
                end
            endcase

            unique case (kp_cur)
                KP_LINE_START: begin
                    if (to_lower(c) == key_char(pos)) begin
                        if (pos == 4'(KEY_LEN - 1)) begin
                            kp_next  = KP_FOUND;
                            kmp_next = 4'd0;
                            np_next  = NP_SPACE;
                        end else begin
                            kmp_next = pos + 4'd1;
                        end
                    end else begin
                        kmp_next = 4'd0;
                        kp_next  = (prev_cr && c == CH_LF) ? KP_LINE_START : KP_SKIP_LINE;
                    end
                end
                KP_SKIP_LINE: begin
                    if (prev_cr && c == CH_LF) begin
                        kp_next  = KP_LINE_START;
                        kmp_next = 4'd0;
                    end
                end
                default: begin
                end
            endcase

            if (c == CH_CR) begin
                eol_next = (eol_cur == EOL_CRLF) ? EOL_CRLFCR : EOL_CR;
            end else if (c == CH_LF && eol_cur == EOL_CR) begin
                eol_next = EOL_CRLF;
            end else if (c == CH_LF && eol_cur == EOL_CRLFCR) begin
                eol_next   = EOL_NONE;
                hdr_next   = 1'b1;
                found_now  = 1'b1;
                total_next = hdr_sum[LW-1:0];
                if (np_next != NP_IDLE) begin
                    np_next = NP_DONE;
                end
                if (hdr_sum[LW]) begin
                    err_next = 1'b1;
                end
            end else begin
                eol_next = EOL_NONE;
            end
        end
    end

    // On the header's last byte the count equals the header length, so the
    // message is already complete only when the content length is zero.
    always_comb begin
        if (found_now) begin
            done = !err_next && (cv_cur == '0);
        end else begin
            done = hdr_next && !err_next && (bytes_next >= total_cur);
        end
        total_ext                = (hdr_next && !err_next) ? 64'(total_next) : 64'd0;
        result_next.header_found = hdr_next;
        result_next.complete     = done;
        result_next.length_error = err_next;
        result_next.total_length = total_ext[TOTAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eol_reg       <= EOL_NONE;
            hdr_reg       <= 1'b0;
            kp_reg        <= KP_LINE_START;
            kmp_reg       <= 4'd0;
            np_reg        <= NP_IDLE;
            err_reg       <= 1'b0;
            bytes_reg     <= '0;
            cv_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                eol_reg       <= eol_next;
                hdr_reg       <= hdr_next;
                kp_reg        <= kp_next;
                kmp_reg       <= kmp_next;
                np_reg        <= np_next;
                err_reg       <= err_next;
                bytes_reg     <= bytes_next;
                cv_reg        <= cv_next;
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule

>>> hw/rtl/http_message_length_framer.sv
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_data_byte, s_first
// m_        out        m_valid, m_ready, m_header_found, m_complete,
//                      m_length_error, m_total_length
//
// One byte per cycle while m_ready takes each result; each result is registered.
// The scan state updates in one step between the input register and the
// result register, so throughput is set only by m_ready.
// Reset is synchronous and active low and clears all scan state.
// A held result stalls the scan stage; the input register still takes one beat.
module http_message_length_framer #(
    parameter int LENGTH_BITS = hmlf_pkg::LENGTH_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_data_byte,
    input  logic                         s_first,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_header_found,
    output logic                         m_complete,
    output logic                         m_length_error,
    output logic [hmlf_pkg::TOTAL_W-1:0] m_total_length
);
    import hmlf_pkg::*;

    in_beat_t s_beat;
    in_beat_t beat;
    logic     beat_valid;
    logic     beat_take;
    result_t  result;

    assign s_beat.data_byte = s_data_byte;
    assign s_beat.first     = s_first;

    hmlf_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    hmlf_scan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_header_found = result.header_found;
    assign m_complete     = result.complete;
    assign m_length_error = result.length_error;
    assign m_total_length = result.total_length;

endmodule

>>> hw/rtl/hmlf_checker.sv
`include "assert_macros.svh"

module hmlf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [7:0]                   s_data_byte,
    input logic                         s_first,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_header_found,
    input logic                         m_complete,
    input logic                         m_length_error,
    input logic [hmlf_pkg::TOTAL_W-1:0] m_total_length
);

    // A message cannot be complete before its header end or with a bad length.
    `ASSERT_SAME(a_complete_needs_header, aclk, aresetn, m_valid && m_complete,
        m_header_found && !m_length_error, "complete without a clean header")

    // The total is only reported for a found header with no error.
    `ASSERT_SAME(a_total_zero_when_unknown, aclk, aresetn,
        m_valid && (!m_header_found || m_length_error), m_total_length == '0,
        "total length nonzero before header end or after an error")

    // With no result waiting, the input side always has room for a beat.
    `ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready,
        "input stalled with no result waiting")

    // A stalled result holds its payload.
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_header_found) && $stable(m_complete)
            && $stable(m_length_error) && $stable(m_total_length),
        "result changed while stalled")

endmodule

bind http_message_length_framer hmlf_checker u_hmlf_checker (.*);

>>> dv/tb_http_message_length_framer.sv
module tb_http_message_length_framer;
    import hmlf_pkg::*;

    localparam logic [31:0]            LEN_LIMIT = 32'hFFFF_FFFF;
    localparam logic [8*KEY_LEN-1:0]   KEY_TEXT  = "content-length:";

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte    = 8'h00;
    logic                s_first        = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_header_found;
    logic                m_complete;
    logic                m_length_error;
    logic [TOTAL_W-1:0]  m_total_length;

    // Control of the idling pattern: quiet on both channels, hold_rx on the output only.
    logic                quiet          = 1'b0;
    logic                hold_rx        = 1'b0;

    result_t             length_reports[$];
    result_t             want;
    logic [7:0]          msg[$];
    int                  beats_sent     = 0;
    int                  mismatches     = 0;

    // Scan state of the framer as the testbench sees it.
    eol_state_t          eol_q;
    logic                hdr_done;
    logic [31:0]         hdr_len;
    logic [31:0]         seen_cnt;
    key_phase_t          key_ph;
    logic [3:0]          key_pos;
    num_phase_t          num_ph;
    logic                neg_q;
    logic [31:0]         len_val;
    logic                err_q;

    http_message_length_framer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first        (s_first),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_header_found (m_header_found),
        .m_complete     (m_complete),
        .m_length_error (m_length_error),
        .m_total_length (m_total_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("[http_message_length_framer] ERROR");
        $finish;
    end

    function automatic void clear_scan();
        eol_q    = EOL_NONE;
        hdr_done = 1'b0;
        hdr_len  = '0;
        seen_cnt = '0;
        key_ph   = KP_LINE_START;
        key_pos  = '0;
        num_ph   = NP_IDLE;
        neg_q    = 1'b0;
        len_val  = '0;
        err_q    = 1'b0;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void take_digits(input logic [7:0] c);
        logic [31:0] d;
        d = {24'd0, c - CH_ZERO};
        case (num_ph)
            NP_SPACE: begin
                if (blank_char(c)) begin
                end else if (c == CH_PLUS) begin
                    num_ph = NP_DIGITS;
                end else if (c == CH_MINUS) begin
                    neg_q  = 1'b1;
                    err_q  = 1'b1;
                    num_ph = NP_DONE;
                end else if (digit_char(c)) begin
                    len_val = d;
                    num_ph  = NP_DIGITS;
                end else begin
                    num_ph = NP_DONE;
                end
            end
            NP_DIGITS: begin
                if (digit_char(c)) begin
                    // The next decimal step must still fit in the length width.
                    if (len_val > (LEN_LIMIT - d) / 32'd10) begin
                        err_q  = 1'b1;
                        num_ph = NP_DONE;
                    end else begin
                        len_val = len_val * 32'd10 + d;
                    end
                end else begin
                    num_ph = NP_DONE;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void match_line(input logic [7:0] c, input logic prev_cr);
        int pos;
        pos = (key_pos < KEY_LEN) ? int'(key_pos) : 0;
        case (key_ph)
            KP_LINE_START: begin
                if (fold_case(c) == KEY_TEXT[(KEY_LEN-1-pos)*8 +: 8]) begin
                    pos++;
                    if (pos >= KEY_LEN) begin
                        key_ph  = KP_FOUND;
                        key_pos = '0;
                        num_ph  = NP_SPACE;
                    end else begin
                        key_pos = pos[3:0];
                    end
                end else begin
                    key_pos = '0;
                    key_ph  = (prev_cr && c == CH_LF) ? KP_LINE_START : KP_SKIP_LINE;
                end
            end
            KP_SKIP_LINE: begin
                if (prev_cr && c == CH_LF) begin
                    key_ph  = KP_LINE_START;
                    key_pos = '0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic result_t frame_byte(input logic [7:0] c, input logic restart);
        result_t     r;
        logic        prev_cr;
        logic [31:0] total;
        if (restart) begin
            clear_scan();
        end
        if (seen_cnt < LEN_LIMIT) begin
            seen_cnt++;
        end
        if (!hdr_done) begin
            prev_cr = (eol_q == EOL_CR) || (eol_q == EOL_CRLFCR);
            if (c == CH_NUL) begin
                err_q = 1'b1;
            end
            take_digits(c);
            match_line(c, prev_cr);
            if (c == CH_CR) begin
                eol_q = (eol_q == EOL_CRLF) ? EOL_CRLFCR : EOL_CR;
            end else if (c == CH_LF && eol_q == EOL_CR) begin
                eol_q = EOL_CRLF;
            end else if (c == CH_LF && eol_q == EOL_CRLFCR) begin
                eol_q    = EOL_NONE;
                hdr_done = 1'b1;
                hdr_len  = seen_cnt;
                if (num_ph != NP_IDLE) begin
                    num_ph = NP_DONE;
                end
                if (len_val > LEN_LIMIT - hdr_len) begin
                    err_q = 1'b1;
                end
            end else begin
                eol_q = EOL_NONE;
            end
        end
        total          = (hdr_done && !err_q) ? hdr_len + len_val : '0;
        r.header_found = hdr_done;
        r.complete     = hdr_done && !err_q && (seen_cnt >= total);
        r.length_error = err_q;
        r.total_length = total;
        return r;
    endfunction

    always @(posedge aclk) begin
        m_ready <= !hold_rx && (quiet || $urandom_range(0, 99) >= 27);
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (length_reports.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %0d/%0d/%0d/%0d",
                         $time, m_header_found, m_complete, m_length_error,
                         m_total_length);
                mismatches++;
            end else begin
                want = length_reports.pop_front();
                check_field("header_found", want.header_found, m_header_found);
                check_field("complete", want.complete, m_complete);
                check_field("length_error", want.length_error, m_length_error);
                check_field("total_length", want.total_length, m_total_length);
            end
        end
    end

    // Valid is left high after a beat is taken, so the next call either drops it
    // for a gap or puts the next byte straight on the bus.
    task automatic send_beat(input logic [7:0] b, input logic restart);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 27) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_first     <= restart;
        do @(posedge aclk); while (!s_ready);
        length_reports.push_back(frame_byte(b, restart));
        beats_sent++;
    endtask

    task automatic send_msg(input logic restart);
        foreach (msg[i]) begin
            send_beat(msg[i], (i == 0) ? restart : 1'b0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (length_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            msg.push_back(s[i]);
        end
    endfunction

    function automatic void add_eol();
        msg.push_back(CH_CR);
        msg.push_back(CH_LF);
    endfunction

    function automatic void add_line(input string s);
        add_text(s);
        add_eol();
    endfunction

    function automatic void add_header_line();
        add_text("X-");
        msg.push_back(8'h61 + 8'($urandom_range(0, 25)));
        add_text(": ");
        msg.push_back(8'($urandom_range(33, 126)));
        add_eol();
    endfunction

    // Builds one message: mostly well-formed headers with a length line of
    // random case, spacing, sign and size, some broken or cut short, some noise.
    function automatic void gen_message();
        int          kind;
        int          body_len;
        int          bad_pos;
        int          r;
        logic [7:0]  c;
        string       num;
        msg.delete();
        kind = $urandom_range(0, 99);
        if (kind < 18) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 5))
                    0:       c = CH_CR;
                    1:       c = CH_LF;
                    2:       c = CH_NUL;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                msg.push_back(c);
            end
            return;
        end
        body_len = $urandom_range(0, 3);
        repeat ($urandom_range(0, 2)) add_header_line();
        if ($urandom_range(0, 99) < 85) begin
            bad_pos = ($urandom_range(0, 99) < 8) ? $urandom_range(0, KEY_LEN - 1) : -1;
            for (int i = 0; i < KEY_LEN; i++) begin
                c = KEY_TEXT[(KEY_LEN-1-i)*8 +: 8];
                if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
                    c = c - 8'd32;
                end
                if (i == bad_pos) begin
                    c = 8'h78;
                end
                msg.push_back(c);
            end
            repeat ($urandom_range(0, 2)) begin
                msg.push_back(($urandom_range(0, 1) == 1) ? CH_TAB : CH_SPACE);
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                msg.push_back(CH_PLUS);
            end else if (r < 15) begin
                msg.push_back(CH_MINUS);
            end
            if ($urandom_range(0, 9) == 0) begin
                add_text("00");
            end
            r = $urandom_range(0, 99);
            if (r < 75) begin
                body_len = $urandom_range(0, 20);
                num      = $sformatf("%0d", body_len);
            end else if (r < 88) begin
                num = $sformatf("%0d", $urandom);
            end else begin
                num = $sformatf("%0d%0d", $urandom_range(4, 9), $urandom);
            end
            add_text(num);
            add_eol();
            if ($urandom_range(0, 99) < 15) begin
                add_line("content-length: 7");
            end
        end
        add_eol();
        repeat (body_len + $urandom_range(0, 2)) begin
            msg.push_back(8'($urandom_range(0, 255)));
        end
        if (kind >= 90) begin
            r = $urandom_range(1, msg.size());
            while (msg.size() > r) void'(msg.pop_back());
        end
    endfunction

    task automatic test_directed();
        msg.delete();
        add_line("GET / HTTP/1.1");
        add_line("Content-Length: 5");
        add_eol();
        add_text("hello");
        msg.push_back(8'hFF);
        send_msg(1'b1);

        // Mixed-case key and a plus sign.
        msg.delete();
        add_line("CONTENT-length:+3");
        add_eol();
        add_text("abc");
        send_msg(1'b1);

        // No length line at all; a zero byte after the header end is harmless.
        msg.delete();
        add_line("Host: a");
        add_eol();
        msg.push_back(CH_NUL);
        send_msg(1'b1);

        msg.delete();
        add_line("Content-Length: -3");
        add_eol();
        add_text("abc");
        send_msg(1'b1);

        // Blanks after the key run into the header end.
        msg.delete();
        add_line("Content-Length: \t");
        add_eol();
        send_msg(1'b1);

        msg.delete();
        add_line("content-length:+");
        add_eol();
        send_msg(1'b1);

        msg.delete();
        add_line("Content-Length: 4294967296");
        add_eol();
        send_msg(1'b1);

        // The value fits alone but not with the header length added.
        msg.delete();
        add_line("Content-Length:4294967290");
        add_eol();
        send_msg(1'b1);

        msg.delete();
        msg.push_back(8'h48);
        msg.push_back(CH_NUL);
        add_line(": x");
        add_eol();
        send_msg(1'b1);

        // Only the first length line counts.
        msg.delete();
        add_line("Content-Length: 2");
        add_line("Content-Length: 9");
        add_eol();
        add_text("xy");
        send_msg(1'b1);

        // A restart in the middle of a key, then a bare LF that ends no line.
        msg.delete();
        add_text("Content-Len");
        send_msg(1'b1);
        msg.delete();
        msg.push_back(CH_LF);
        add_line("Content-Length: 1");
        add_eol();
        add_text("z");
        send_msg(1'b1);

        // More bytes without a restart only advance the count.
        msg.delete();
        add_text("pq");
        send_msg(1'b0);
    endtask

    task automatic test_random_messages(input int n_beats);
        int stop_at;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            gen_message();
            send_msg($urandom_range(0, 99) < 95);
        end
    endtask

    task automatic test_output_stall();
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_rx <= 1'b0;
            end
        join_none
        test_random_messages(50);
        drain_results();
    endtask

    task automatic test_burst();
        quiet <= 1'b1;
        test_random_messages(90);
        quiet <= 1'b0;
        drain_results();
    endtask

    initial begin
        clear_scan();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        drain_results();
        test_random_messages(40);
        drain_results();
        test_output_stall();
        test_burst();
        test_random_messages(20);
        drain_results();
        if (mismatches == 0) begin
            $display("[http_message_length_framer] OK");
        end else begin
            $display("[http_message_length_framer] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hmlf_pkg.sv
hw/rtl/hmlf_in_stage.sv
hw/rtl/hmlf_scan.sv
hw/rtl/http_message_length_framer.sv
hw/rtl/hmlf_checker.sv
dv/tb_http_message_length_framer.sv
